>>> sv/tqcs_pkg.sv
// Shared types and constants of the timestamp quorum clock synchronizer.
// Holds the stream item layouts, config register map, result codes and states.
// No dependencies; every other file of the block imports it.
package tqcs_pkg;

    localparam int DATA_W      = 32;
    localparam int KEY_W       = DATA_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 168;

    // request kinds carried on s_tuser
    localparam logic [1:0] KIND_ADVERT  = 2'd0;
    localparam logic [1:0] KIND_MESSAGE = 2'd1;
    localparam logic [1:0] KIND_SYNC    = 2'd2;

    // sync result codes
    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_CLOCK = 2'd1;
    localparam logic [1:0] RES_GPS   = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SPAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT  = 3'd4;

    // config reset values
    localparam logic [DATA_W-1:0] RST_VALID_MIN    = 32'd0;
    localparam logic [DATA_W-1:0] RST_VALID_MAX    = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] RST_JUMP_LIMIT   = 32'd86400;
    localparam logic [DATA_W-1:0] RST_CLUSTER_SPAN = 32'd60;
    localparam logic [DATA_W-1:0] RST_DRIFT_LIMIT  = 32'd2;

    // quorum sizes and largest-cluster ceiling
    localparam int         QUORUM_UNSET = 3;
    localparam int         QUORUM_FULL  = 7;
    localparam logic [3:0] LARGEST_MAX  = 4'd15;

    // sort key of an empty slot, above every real sample
    localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] valid_min;
        logic [DATA_W-1:0] valid_max;
        logic [DATA_W-1:0] jump_limit;
        logic [DATA_W-1:0] cluster_span;
        logic [DATA_W-1:0] drift_limit;
    } cfg_t;

    typedef struct packed {
        logic              lt;      // op_a < op_b
        logic              d_lt_c;  // (op_a - op_b) < op_c
        logic              d_le_c;  // (op_a - op_b) <= op_c
        logic [DATA_W-1:0] diff;    // op_a - op_b, low word
    } alu_res_t;

    typedef struct packed {
        logic [4:0]        pad;
        logic              gps_ready;
        logic              app_locked;
        logic              clock_reliable;
        logic [DATA_W-1:0] current_time;
        logic [DATA_W-1:0] sample_time;
    } in_item_t;

    typedef struct packed {
        logic              pad;
        logic [DATA_W-1:0] valid_total;
        logic [DATA_W-1:0] advert_total;
        logic [3:0]        best_cluster_seen;
        logic [DATA_W-1:0] sync_total;
        logic [DATA_W-1:0] adjustment;
        logic [DATA_W-1:0] new_time;
        logic [1:0]        sync_result;
        logic              accepted;
    } out_item_t;

    typedef enum logic [18:0] {
        ST_IDLE      = 19'h00001,
        ST_CHK_LO    = 19'h00002,
        ST_CHK_HI    = 19'h00004,
        ST_JMP_DIR   = 19'h00008,
        ST_JMP_CMP   = 19'h00010,
        ST_STORE     = 19'h00020,
        ST_SYNC_INIT = 19'h00040,
        ST_GATHER    = 19'h00080,
        ST_SORT      = 19'h00100,
        ST_COPY      = 19'h00200,
        ST_SCAN_RD   = 19'h00400,
        ST_SCAN_CMP  = 19'h00800,
        ST_SCAN_END  = 19'h01000,
        ST_MED_RD    = 19'h02000,
        ST_MED_DIR   = 19'h04000,
        ST_MED_DRIFT = 19'h08000,
        ST_MED_JUMP  = 19'h10000,
        ST_APPLY     = 19'h20000,
        ST_EMIT      = 19'h40000
    } state_t;

endpackage

>>> sv/tqcs_alu.sv
// Shared subtract and compare unit of the synchronizer sequencer.
// One wide subtract with borrow, then the difference compared to a limit.
// Depends on tqcs_pkg.
module tqcs_alu
    import tqcs_pkg::*;
(
    input  logic [KEY_W-1:0]  op_a,
    input  logic [KEY_W-1:0]  op_b,
    input  logic [DATA_W-1:0] op_c,
    output alu_res_t          res
);

    logic [KEY_W:0]    sub;
    logic [DATA_W-1:0] diff;
    logic              d_lt;

    // subtract with borrow out
    assign sub  = {1'b0, op_a} - {1'b0, op_b};
    assign diff = sub[DATA_W-1:0];

    // difference against the limit
    assign d_lt = diff < op_c;

    assign res.lt     = sub[KEY_W];
    assign res.diff   = diff;
    assign res.d_lt_c = d_lt;
    assign res.d_le_c = d_lt | (diff == op_c);

endmodule

>>> sv/tqcs_cfg.sv
// Configuration register file of the synchronizer.
// Takes requests on the config write channel; indexes past the map are dropped.
// Depends on tqcs_pkg.
module tqcs_cfg
    import tqcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VALID_MIN:    cfg_next.valid_min    = cfg_data;
                CFG_VALID_MAX:    cfg_next.valid_max    = cfg_data;
                CFG_JUMP_LIMIT:   cfg_next.jump_limit   = cfg_data;
                CFG_CLUSTER_SPAN: cfg_next.cluster_span = cfg_data;
                CFG_DRIFT_LIMIT:  cfg_next.drift_limit  = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.valid_min    <= RST_VALID_MIN;
            cfg_reg.valid_max    <= RST_VALID_MAX;
            cfg_reg.jump_limit   <= RST_JUMP_LIMIT;
            cfg_reg.cluster_span <= RST_CLUSTER_SPAN;
            cfg_reg.drift_limit  <= RST_DRIFT_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/timestamp_quorum_clock_sync_top.sv
// Top level of the timestamp quorum clock synchronizer: sequencer, sample ring,
// sort line and sorted sample memory around one shared subtract/compare unit.
// Depends on tqcs_pkg, tqcs_alu and tqcs_cfg.
//
//   channel   direction  handshake              payload
//   s_        in         s_tvalid / s_tready    s_tdata, s_tuser (kind)
//   m_        out        m_tvalid / m_tready    m_tdata
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Path from the accepting edge to m_tvalid: an advert or message passes the
// bound checks and the ring write, a message with jump check also the jump
// states; a locked sync or unused kind goes straight to emit, a sync below
// quorum after the window setup; a full sync gathers, sorts, copies and scans.
// Reset is synchronous; the ring has no clearing pass, the fill count guards it.
// s_tready is high only when idle; a result held by m_tready stalls the next one.
module timestamp_quorum_clock_sync_top
    import tqcs_pkg::*;
#(
    parameter int RING_DEPTH   = 10,
    parameter int UNSET_WINDOW = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sample_time, current_time, clock_reliable, app_locked, gps_ready, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // accepted, sync_result, new_time, adjustment, sync_total,
    // best_cluster_seen, advert_total, valid_total, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int CAP_UNSET = (UNSET_WINDOW < RING_DEPTH) ? UNSET_WINDOW : RING_DEPTH;
    localparam int CMP_W     = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [CNT_W-1:0]  DEPTH_C     = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  LAST_STEP   = CNT_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  LAST_PASS   = CNT_W'(RING_DEPTH - 2);
    localparam logic [CNT_W-1:0]  CAP_UNSET_C = CNT_W'(CAP_UNSET);
    localparam logic [CNT_W-1:0]  Q_UNSET_C   = CNT_W'(QUORUM_UNSET);
    localparam logic [CNT_W-1:0]  Q_FULL_C    = CNT_W'(QUORUM_FULL);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(RING_DEPTH - 1);

    cfg_t     cfg;
    in_item_t in_item;
    alu_res_t alu;

    logic [KEY_W-1:0]  alu_a;
    logic [KEY_W-1:0]  alu_b;
    logic [DATA_W-1:0] alu_c;

    state_t state_reg, state_next;

    // request fields
    logic [1:0]        kind_reg, kind_next;
    logic [DATA_W-1:0] ts_reg, ts_next;
    logic [DATA_W-1:0] now_reg, now_next;
    logic              reliable_reg, reliable_next;
    logic              gps_reg, gps_next;

    // per-request working flags
    logic              ok_reg, ok_next;
    logic              swap_reg, swap_next;
    logic              unset_reg, unset_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  quorum_reg, quorum_next;

    // persistent state
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [DATA_W-1:0] sync_cnt_reg, sync_cnt_next;
    logic [DATA_W-1:0] advert_cnt_reg, advert_cnt_next;
    logic [DATA_W-1:0] valid_cnt_reg, valid_cnt_next;
    logic [3:0]        largest_reg, largest_next;
    logic [DATA_W-1:0] last_adj_reg, last_adj_next;

    // result fields
    logic              accepted_reg, accepted_next;
    logic [1:0]        result_reg, result_next;
    logic [DATA_W-1:0] new_time_reg, new_time_next;
    logic [DATA_W-1:0] med_reg, med_next;

    // sequencing counters
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [SLOT_W-1:0] rd_addr_reg, rd_addr_next;
    logic [KEY_W-1:0]  carry_reg, carry_next;

    // sort line
    logic [KEY_W-1:0]  line_reg [RING_DEPTH];
    logic [KEY_W-1:0]  line_next [RING_DEPTH];
    logic              line_shift;
    logic [KEY_W-1:0]  line_tail;

    // cluster scan
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic [CNT_W-1:0]  start_reg, start_next;

    // memories
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    logic [DATA_W-1:0] ring_rd_reg;
    logic              ring_we;
    logic [DATA_W-1:0] sorted_mem [RING_DEPTH];
    logic [DATA_W-1:0] rd_i_reg;
    logic [DATA_W-1:0] rd_e_reg;
    logic              sorted_we;
    logic [SLOT_W-1:0] rd_i_addr;
    logic [SLOT_W-1:0] rd_e_addr;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    out_item_t         m_tdata_reg, m_tdata_next;

    // derived values
    logic              sync_unset;
    logic [CNT_W-1:0]  sync_cap;
    logic [CNT_W-1:0]  sync_quorum;
    logic [CNT_W-1:0]  run_len;
    logic [CNT_W-1:0]  med_idx;
    logic [CMP_W-1:0]  best_wide;
    logic [CMP_W-1:0]  largest_wide;

    tqcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tqcs_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .op_c (alu_c),
        .res  (alu)
    );

    assign in_item  = s_tdata;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // sync mode selection
    assign sync_unset  = !reliable_reg && (sync_cnt_reg == '0);
    assign sync_cap    = sync_unset ? CAP_UNSET_C : DEPTH_C;
    assign sync_quorum = sync_unset ? Q_UNSET_C : Q_FULL_C;

    // cluster bookkeeping
    assign run_len      = e_reg - i_reg;
    assign med_idx      = start_reg + (best_reg >> 1);
    assign best_wide    = CMP_W'(best_reg);
    assign largest_wide = CMP_W'(largest_reg);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        ts_next         = ts_reg;
        now_next        = now_reg;
        reliable_next   = reliable_reg;
        gps_next        = gps_reg;
        ok_next         = ok_reg;
        swap_next       = swap_reg;
        unset_next      = unset_reg;
        n_next          = n_reg;
        quorum_next     = quorum_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        sync_cnt_next   = sync_cnt_reg;
        advert_cnt_next = advert_cnt_reg;
        valid_cnt_next  = valid_cnt_reg;
        largest_next    = largest_reg;
        last_adj_next   = last_adj_reg;
        accepted_next   = accepted_reg;
        result_next     = result_reg;
        new_time_next   = new_time_reg;
        med_next        = med_reg;
        step_next       = step_reg;
        pass_next       = pass_reg;
        rd_addr_next    = rd_addr_reg;
        carry_next      = carry_reg;
        i_next          = i_reg;
        e_next          = e_reg;
        best_next       = best_reg;
        start_next      = start_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_c           = '0;
        line_shift      = 1'b0;
        line_tail       = line_reg[0];
        ring_we         = 1'b0;
        sorted_we       = 1'b0;
        rd_i_addr       = i_reg[SLOT_W-1:0];
        rd_e_addr       = (e_reg < n_reg) ? e_reg[SLOT_W-1:0] : '0;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next     = s_tuser;
                    ts_next       = in_item.sample_time;
                    now_next      = in_item.current_time;
                    reliable_next = in_item.clock_reliable;
                    gps_next      = in_item.gps_ready;
                    ok_next       = 1'b1;
                    accepted_next = 1'b0;
                    result_next   = RES_NONE;
                    new_time_next = '0;
                    if (s_tuser == KIND_ADVERT || s_tuser == KIND_MESSAGE) begin
                        state_next = ST_CHK_LO;
                    end else if (s_tuser == KIND_SYNC && !in_item.app_locked) begin
                        state_next = ST_SYNC_INIT;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end

            // lower bound: min < ts
            ST_CHK_LO: begin
                alu_a   = {1'b0, cfg.valid_min};
                alu_b   = {1'b0, ts_reg};
                ok_next = alu.lt;
                if (kind_reg == KIND_ADVERT) begin
                    advert_cnt_next = advert_cnt_reg + 1'b1;
                end
                state_next = ST_CHK_HI;
            end

            // upper bound: ts < max
            ST_CHK_HI: begin
                alu_a   = {1'b0, ts_reg};
                alu_b   = {1'b0, cfg.valid_max};
                ok_next = ok_reg & alu.lt;
                if (kind_reg == KIND_MESSAGE && sync_cnt_reg != '0) begin
                    state_next = ST_JMP_DIR;
                end else begin
                    state_next = ST_STORE;
                end
            end

            // message jump check, order the operands first
            ST_JMP_DIR: begin
                alu_a      = {1'b0, ts_reg};
                alu_b      = {1'b0, now_reg};
                swap_next  = alu.lt;
                state_next = ST_JMP_CMP;
            end

            ST_JMP_CMP: begin
                alu_a      = {1'b0, swap_reg ? now_reg : ts_reg};
                alu_b      = {1'b0, swap_reg ? ts_reg : now_reg};
                alu_c      = cfg.jump_limit;
                ok_next    = ok_reg & alu.d_lt_c;
                state_next = ST_STORE;
            end

            // ring write
            ST_STORE: begin
                if (ok_reg) begin
                    ring_we       = 1'b1;
                    slot_next     = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    fill_next     = (fill_reg == DEPTH_C) ? fill_reg : fill_reg + 1'b1;
                    accepted_next = 1'b1;
                    if (kind_reg == KIND_ADVERT) begin
                        valid_cnt_next = valid_cnt_reg + 1'b1;
                    end
                end
                state_next = ST_EMIT;
            end

            // window size and quorum
            ST_SYNC_INIT: begin
                unset_next   = sync_unset;
                quorum_next  = sync_quorum;
                n_next       = (fill_reg < sync_cap) ? fill_reg : sync_cap;
                step_next    = '0;
                rd_addr_next = (slot_reg == '0) ? LAST_SLOT : slot_reg - 1'b1;
                if (fill_reg < sync_quorum) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_GATHER;
                end
            end

            // newest first out of the ring into the sort line
            ST_GATHER: begin
                rd_addr_next = (rd_addr_reg == '0) ? LAST_SLOT : rd_addr_reg - 1'b1;
                if (step_reg != '0) begin
                    line_shift = 1'b1;
                    line_tail  = (step_reg <= n_reg) ? {1'b0, ring_rd_reg} : KEY_EMPTY;
                end
                if (step_reg == DEPTH_C) begin
                    step_next  = '0;
                    pass_next  = '0;
                    state_next = ST_SORT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            // bubble passes over the line, each moves the largest key to the tail
            ST_SORT: begin
                alu_a      = carry_reg;
                alu_b      = line_reg[0];
                line_shift = 1'b1;
                if (step_reg == '0) begin
                    carry_next = line_reg[0];
                    line_tail  = line_reg[0];
                end else if (step_reg == DEPTH_C) begin
                    line_tail = carry_reg;
                end else begin
                    line_tail  = alu.lt ? carry_reg : line_reg[0];
                    carry_next = alu.lt ? line_reg[0] : carry_reg;
                end
                if (step_reg == DEPTH_C) begin
                    step_next = '0;
                    if (pass_reg == LAST_PASS) begin
                        state_next = ST_COPY;
                    end else begin
                        pass_next = pass_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            // sorted line into the scan memory
            ST_COPY: begin
                sorted_we  = 1'b1;
                line_shift = 1'b1;
                if (step_reg == LAST_STEP) begin
                    i_next     = '0;
                    e_next     = '0;
                    best_next  = '0;
                    start_next = '0;
                    state_next = ST_SCAN_RD;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end

            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end

            // two-pointer cluster search
            ST_SCAN_CMP: begin
                alu_a = {1'b0, rd_e_reg};
                alu_b = {1'b0, rd_i_reg};
                alu_c = cfg.cluster_span;
                if (e_reg < n_reg && alu.d_le_c) begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else begin
                    if (run_len > best_reg) begin
                        best_next  = run_len;
                        start_next = i_reg;
                    end
                    if (i_reg + 1'b1 < n_reg) begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end else begin
                        state_next = ST_SCAN_END;
                    end
                end
            end

            ST_SCAN_END: begin
                if (best_wide > largest_wide) begin
                    largest_next = (best_wide > CMP_W'(LARGEST_MAX)) ?
                                   LARGEST_MAX : best_wide[3:0];
                end
                if (best_reg < quorum_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MED_RD;
                end
            end

            ST_MED_RD: begin
                rd_i_addr  = med_idx[SLOT_W-1:0];
                state_next = ST_MED_DIR;
            end

            // median against current time
            ST_MED_DIR: begin
                med_next  = rd_i_reg;
                alu_a     = {1'b0, rd_i_reg};
                alu_b     = {1'b0, now_reg};
                swap_next = alu.lt;
                if (unset_reg) begin
                    state_next = ST_APPLY;
                end else begin
                    state_next = ST_MED_DRIFT;
                end
            end

            ST_MED_DRIFT: begin
                alu_a = {1'b0, swap_reg ? now_reg : med_reg};
                alu_b = {1'b0, swap_reg ? med_reg : now_reg};
                alu_c = cfg.drift_limit;
                if (alu.d_le_c) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MED_JUMP;
                end
            end

            ST_MED_JUMP: begin
                alu_a = {1'b0, swap_reg ? now_reg : med_reg};
                alu_b = {1'b0, swap_reg ? med_reg : now_reg};
                alu_c = cfg.jump_limit;
                if (alu.d_lt_c) begin
                    state_next = ST_APPLY;
                end else begin
                    state_next = ST_EMIT;
                end
            end

            // commit the correction
            ST_APPLY: begin
                alu_a         = {1'b0, med_reg};
                alu_b         = {1'b0, now_reg};
                last_adj_next = alu.diff;
                sync_cnt_next = sync_cnt_reg + 1'b1;
                result_next   = gps_reg ? RES_GPS : RES_CLOCK;
                new_time_next = gps_reg ? '0 : med_reg;
                state_next    = ST_EMIT;
            end

            // load the output register once it is free
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next                  = 1'b1;
                    m_tdata_next.pad               = 1'b0;
                    m_tdata_next.valid_total       = valid_cnt_reg;
                    m_tdata_next.advert_total      = advert_cnt_reg;
                    m_tdata_next.best_cluster_seen = largest_reg;
                    m_tdata_next.sync_total        = sync_cnt_reg;
                    m_tdata_next.adjustment        = last_adj_reg;
                    m_tdata_next.new_time          = new_time_reg;
                    m_tdata_next.sync_result       = result_reg;
                    m_tdata_next.accepted          = accepted_reg;
                    state_next                     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sort line shift
    always_comb begin
        for (int k = 0; k < RING_DEPTH; k++) begin
            line_next[k] = line_reg[k];
        end
        if (line_shift) begin
            for (int k = 0; k < RING_DEPTH - 1; k++) begin
                line_next[k] = line_reg[k + 1];
            end
            line_next[RING_DEPTH-1] = line_tail;
        end
    end

    // control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            sync_cnt_reg   <= '0;
            advert_cnt_reg <= '0;
            valid_cnt_reg  <= '0;
            largest_reg    <= '0;
            last_adj_reg   <= '0;
            rd_addr_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            sync_cnt_reg   <= sync_cnt_next;
            advert_cnt_reg <= advert_cnt_next;
            valid_cnt_reg  <= valid_cnt_next;
            largest_reg    <= largest_next;
            last_adj_reg   <= last_adj_next;
            rd_addr_reg    <= rd_addr_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        ts_reg       <= ts_next;
        now_reg      <= now_next;
        reliable_reg <= reliable_next;
        gps_reg      <= gps_next;
        ok_reg       <= ok_next;
        swap_reg     <= swap_next;
        unset_reg    <= unset_next;
        n_reg        <= n_next;
        quorum_reg   <= quorum_next;
        accepted_reg <= accepted_next;
        result_reg   <= result_next;
        new_time_reg <= new_time_next;
        med_reg      <= med_next;
        step_reg     <= step_next;
        pass_reg     <= pass_next;
        carry_reg    <= carry_next;
        i_reg        <= i_next;
        e_reg        <= e_next;
        best_reg     <= best_next;
        start_reg    <= start_next;
        m_tdata_reg  <= m_tdata_next;
        for (int k = 0; k < RING_DEPTH; k++) begin
            line_reg[k] <= line_next[k];
        end
    end

    // sample ring, one write and one registered read
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= ts_reg;
        end
        ring_rd_reg <= ring_mem[rd_addr_reg];
    end

    // sorted samples, one write and two registered reads
    always_ff @(posedge aclk) begin
        if (sorted_we) begin
            sorted_mem[step_reg[SLOT_W-1:0]] <= line_reg[0][DATA_W-1:0];
        end
        rd_i_reg <= sorted_mem[rd_i_addr];
        rd_e_reg <= sorted_mem[rd_e_addr];
    end

endmodule
